/* rtl/rlex_pkg.sv */
// rlex_pkg: shared types and constants for the run-length text expander
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rlex_pkg;

   localparam int MAX_RUN_DEFAULT     = 64;
   localparam int TOTAL_WIDTH_DEFAULT = 16;

   // count register covers the largest legal run limit
   localparam int COUNT_WIDTH  = 7;
   localparam int CHAR_WIDTH   = 8;
   localparam int SHOWN_WIDTH  = 16;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [CHAR_WIDTH-1:0] DIGIT_LOW  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] DIGIT_HIGH = 8'd57;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } result_kind_type;

   // one classified item handed from the front to the back
   typedef struct packed {
      result_kind_type             kind;
      logic [CHAR_WIDTH-1:0]       char_value;
      logic [COUNT_WIDTH-1:0]      copies;
      logic [SHOWN_WIDTH-1:0]      shown_total;
   } command_type;

endpackage

`default_nettype wire

/* rtl/rle_text_expander_unit.sv */
// rle_text_expander_unit: run-length text decoder with decimal counts
// a result is registered in the command queue and then in the output register
// throughput: one byte per cycle while the command queue has room; a symbol with
// count n yields n result transfers, one per cycle while rsp_ready is high
// reset: synchronous, active high; clears count, total, error flag, queue and output
`timescale 1ns / 1ps
`default_nettype none

module rle_text_expander_unit
   import rlex_pkg::*;
#(
   parameter int MAX_RUN     = MAX_RUN_DEFAULT,
   parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [CHAR_WIDTH-1:0] req_symbol_byte,
   input  wire logic                  req_end_of_string,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_result_kind,
   output logic [CHAR_WIDTH-1:0]      rsp_out_char,
   output logic [SHOWN_WIDTH-1:0]     rsp_char_total,
   output logic                       rsp_last_of_run
);

   logic        queue_full;
   logic        push_valid;
   command_type push_command;
   logic        pop_ready;
   logic        pop_take;
   command_type pop_command;

   rlex_front #(
      .MAX_RUN     (MAX_RUN),
      .TOTAL_WIDTH (TOTAL_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_symbol_byte   (req_symbol_byte),
      .req_end_of_string (req_end_of_string),
      .queue_full        (queue_full),
      .push_valid        (push_valid),
      .push_command      (push_command)
   );

   rlex_cmd_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid   (push_valid),
      .push_command (push_command),
      .full         (queue_full),
      .pop_ready    (pop_ready),
      .pop_take     (pop_take),
      .pop_command  (pop_command)
   );

   rlex_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_ready       (pop_ready),
      .pop_command     (pop_command),
      .pop_take        (pop_take),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_char    (rsp_out_char),
      .rsp_char_total  (rsp_char_total),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

/* rtl/rlex_front.sv */
// rlex_front: accepts coded bytes, builds counts, tracks the running total
// and the error flag, and pushes one command per result-producing byte; uses rlex_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlex_front
   import rlex_pkg::*;
#(
   parameter int MAX_RUN     = MAX_RUN_DEFAULT,
   parameter int TOTAL_WIDTH = TOTAL_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [CHAR_WIDTH-1:0] req_symbol_byte,
   input  wire logic                  req_end_of_string,
   input  wire logic                  queue_full,
   output logic                       push_valid,
   output command_type                push_command
);

   localparam int NEXT_WIDTH = COUNT_WIDTH + 4;
   localparam int CMP_WIDTH  = (TOTAL_WIDTH > SHOWN_WIDTH) ? TOTAL_WIDTH : SHOWN_WIDTH;

   logic [COUNT_WIDTH-1:0] pending_ff, pending_in;
   logic [TOTAL_WIDTH-1:0] total_ff, total_in;
   logic                   failed_ff, failed_in;

   logic                   accept;
   logic                   is_digit;
   logic [3:0]             digit;
   logic [NEXT_WIDTH-1:0]  next_count;
   logic [TOTAL_WIDTH:0]   total_sum;
   logic [CMP_WIDTH-1:0]   total_wide;
   logic [SHOWN_WIDTH-1:0] total_shown;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   assign is_digit   = (req_symbol_byte >= DIGIT_LOW) && (req_symbol_byte <= DIGIT_HIGH);
   assign digit      = 4'(req_symbol_byte - DIGIT_LOW);
   // count times ten as two shifted copies
   assign next_count = {pending_ff, 3'b000} + {1'b0, pending_ff, 1'b0}
                       + NEXT_WIDTH'(digit);
   assign total_sum  = {1'b0, total_ff} + (TOTAL_WIDTH + 1)'(pending_ff);

   assign total_wide  = CMP_WIDTH'(total_ff);
   assign total_shown = (total_wide > CMP_WIDTH'({SHOWN_WIDTH{1'b1}})) ?
                        {SHOWN_WIDTH{1'b1}} : total_wide[SHOWN_WIDTH-1:0];

   always_comb begin
      pending_in              = pending_ff;
      total_in                = total_ff;
      failed_in               = failed_ff;
      push_valid              = 1'b0;
      push_command.kind       = KIND_ERROR;
      push_command.char_value = '0;
      push_command.copies     = '0;
      push_command.shown_total = '0;
      if (accept) begin
         if (req_end_of_string) begin
            // error already reported: end marker stays silent
            push_valid = !failed_ff;
            if (pending_ff == '0) begin
               push_command.kind        = KIND_DONE;
               push_command.shown_total = total_shown;
            end
            pending_in = '0;
            total_in   = '0;
            failed_in  = 1'b0;
         end else if (!failed_ff) begin
            if (is_digit) begin
               if (((pending_ff == '0) && (digit == 4'd0))
                   || (next_count > NEXT_WIDTH'(MAX_RUN))) begin
                  push_valid = 1'b1;
                  failed_in  = 1'b1;
                  pending_in = '0;
               end else begin
                  pending_in = next_count[COUNT_WIDTH-1:0];
               end
            end else if (pending_ff == '0) begin
               push_valid = 1'b1;
               failed_in  = 1'b1;
            end else begin
               push_valid              = 1'b1;
               push_command.kind       = KIND_CHAR;
               push_command.char_value = req_symbol_byte;
               push_command.copies     = pending_ff;
               total_in   = total_sum[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}}
                                                   : total_sum[TOTAL_WIDTH-1:0];
               pending_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         total_ff   <= '0;
         failed_ff  <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         total_ff   <= total_in;
         failed_ff  <= failed_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/rlex_cmd_queue.sv */
// rlex_cmd_queue: short command queue between the front and the back
// uses rlex_pkg for the command type
`timescale 1ns / 1ps
`default_nettype none

module rlex_cmd_queue
   import rlex_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_valid,
   input  command_type      push_command,
   output logic             full,
   output logic             pop_ready,
   input  wire logic        pop_take,
   output command_type      pop_command
);

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   command_type            slots_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full        = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign pop_ready   = (count_ff != '0);
   assign pop_command = slots_ff[rd_ptr_ff];
   assign do_push     = push_valid && !full;
   assign do_pop      = pop_take && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_command;
      end
   end

endmodule

`default_nettype wire

/* rtl/rlex_back.sv */
// rlex_back: expands queued commands into result transfers through an output register
// uses rlex_pkg for the command type and result codes
`timescale 1ns / 1ps
`default_nettype none

module rlex_back
   import rlex_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   pop_ready,
   input  command_type                 pop_command,
   output logic                        pop_take,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [1:0]                  rsp_result_kind,
   output logic [CHAR_WIDTH-1:0]       rsp_out_char,
   output logic [SHOWN_WIDTH-1:0]      rsp_char_total,
   output logic                        rsp_last_of_run
);

   logic                      valid_ff, valid_in;
   logic                      active_ff, active_in;
   logic [CHAR_WIDTH-1:0]     run_char_ff, run_char_in;
   logic [COUNT_WIDTH-1:0]    left_ff, left_in;
   result_kind_type           kind_ff, kind_in;
   logic [CHAR_WIDTH-1:0]     char_ff, char_in;
   logic [SHOWN_WIDTH-1:0]    total_ff, total_in;
   logic                      last_ff, last_in;
   logic                      slot_open;

   // output register free or being drained this cycle
   assign slot_open = !valid_ff || rsp_ready;
   assign pop_take  = slot_open && !active_ff && pop_ready;

   always_comb begin
      valid_in    = valid_ff;
      active_in   = active_ff;
      run_char_in = run_char_ff;
      left_in     = left_ff;
      kind_in     = kind_ff;
      char_in     = char_ff;
      total_in    = total_ff;
      last_in     = last_ff;
      if (slot_open) begin
         valid_in = 1'b0;
         if (active_ff) begin
            valid_in  = 1'b1;
            kind_in   = KIND_CHAR;
            char_in   = run_char_ff;
            total_in  = '0;
            last_in   = (left_ff == COUNT_WIDTH'(1));
            left_in   = left_ff - 1'b1;
            active_in = (left_ff != COUNT_WIDTH'(1));
         end else if (pop_ready) begin
            valid_in = 1'b1;
            kind_in  = pop_command.kind;
            unique case (pop_command.kind)
               KIND_CHAR: begin
                  char_in     = pop_command.char_value;
                  total_in    = '0;
                  last_in     = (pop_command.copies == COUNT_WIDTH'(1));
                  run_char_in = pop_command.char_value;
                  left_in     = pop_command.copies - 1'b1;
                  active_in   = (pop_command.copies != COUNT_WIDTH'(1));
               end
               KIND_DONE: begin
                  char_in  = '0;
                  total_in = pop_command.shown_total;
                  last_in  = 1'b1;
               end
               default: begin
                  char_in  = '0;
                  total_in = '0;
                  last_in  = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         active_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      run_char_ff <= run_char_in;
      left_ff     <= left_in;
      kind_ff     <= kind_in;
      char_ff     <= char_in;
      total_ff    <= total_in;
      last_ff     <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_char_total  = total_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

/* bench/rle_text_expander_unit_tb.sv */
// rle_text_expander_unit_tb: self-checking bench for the run-length text expander
// needs rlex_pkg and rle_text_expander_unit; byte driver, result monitor and decoder
// model all live in this module
`timescale 1ns / 1ps

module rle_text_expander_unit_tb;
   import rlex_pkg::*;

   localparam int RUN_LIMIT       = MAX_RUN_DEFAULT;
   localparam int TOTAL_CAP       = (1 << TOTAL_WIDTH_DEFAULT) - 1;
   localparam int SHOWN_CAP       = (1 << SHOWN_WIDTH) - 1;
   localparam int RANDOM_ITEMS    = 200;
   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 8;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] sym;
      logic                  end_mark;
   } coded_item_type;

   typedef struct packed {
      result_kind_type        kind;
      logic [CHAR_WIDTH-1:0]  ch;
      logic [SHOWN_WIDTH-1:0] total;
      logic                   last;
   } decoded_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CHAR_WIDTH-1:0]  req_symbol_byte = '0;
   logic                   req_end_of_string = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_result_kind;
   logic [CHAR_WIDTH-1:0]  rsp_out_char;
   logic [SHOWN_WIDTH-1:0] rsp_char_total;
   logic                   rsp_last_of_run;

   coded_item_type coded_stream[$];
   decoded_type    predicted_outputs[$];
   decoded_type    awaited;
   coded_item_type next_item;

   // decoder model state
   int run_count;
   int char_sum;
   bit string_failed;

   int items_taken;
   int strings_done;
   int results_checked;
   int fail_count;
   int idle_cycles;
   int phase_one_end;
   int phase_two_end;

   rle_text_expander_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_symbol_byte   (req_symbol_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_out_char      (rsp_out_char),
      .rsp_char_total    (rsp_char_total),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // ---------------------------------------------------------------- decoder model

   task automatic push_decoded(input result_kind_type kind, input logic [CHAR_WIDTH-1:0] ch,
                               input int total, input logic last);
      decoded_type d;
      d.kind  = kind;
      d.ch    = ch;
      d.total = SHOWN_WIDTH'((total > SHOWN_CAP) ? SHOWN_CAP : total);
      d.last  = last;
      predicted_outputs.push_back(d);
   endtask

   task automatic flag_malformed();
      string_failed = 1'b1;
      run_count     = 0;
      push_decoded(KIND_ERROR, '0, 0, 1'b1);
   endtask

   task automatic expand_item(input logic [CHAR_WIDTH-1:0] sym, input logic end_mark);
      int digit;
      int grown;
      if (end_mark) begin
         if (!string_failed) begin
            if (run_count != 0)
               push_decoded(KIND_ERROR, '0, 0, 1'b1);
            else
               push_decoded(KIND_DONE, '0, char_sum, 1'b1);
         end
         run_count     = 0;
         char_sum      = 0;
         string_failed = 1'b0;
      end else if (!string_failed) begin
         if (sym >= DIGIT_LOW && sym <= DIGIT_HIGH) begin
            digit = sym - DIGIT_LOW;
            grown = run_count * 10 + digit;
            if (run_count == 0 && digit == 0)
               flag_malformed();
            else if (grown > RUN_LIMIT)
               flag_malformed();
            else
               run_count = grown;
         end else if (run_count == 0) begin
            flag_malformed();
         end else begin
            for (int i = 0; i < run_count; i++)
               push_decoded(KIND_CHAR, sym, 0, i == run_count - 1);
            char_sum  = (char_sum + run_count > TOTAL_CAP) ? TOTAL_CAP : char_sum + run_count;
            run_count = 0;
         end
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic add_byte(input logic [CHAR_WIDTH-1:0] sym);
      coded_item_type c;
      c.sym      = sym;
      c.end_mark = 1'b0;
      coded_stream.push_back(c);
   endtask

   task automatic add_end();
      coded_item_type c;
      c.sym      = CHAR_WIDTH'($urandom_range(255));
      c.end_mark = 1'b1;
      coded_stream.push_back(c);
   endtask

   // decimal count, most significant digit first
   task automatic add_count(input int n);
      if (n >= 10)
         add_byte(CHAR_WIDTH'(DIGIT_LOW + n / 10));
      add_byte(CHAR_WIDTH'(DIGIT_LOW + n % 10));
   endtask

   function automatic logic [CHAR_WIDTH-1:0] random_symbol();
      logic [CHAR_WIDTH-1:0] s;
      s = CHAR_WIDTH'($urandom_range(255));
      while (s >= DIGIT_LOW && s <= DIGIT_HIGH)
         s = CHAR_WIDTH'($urandom_range(255));
      return s;
   endfunction

   // mostly well-formed strings, some broken in one of several ways
   task automatic add_random_string();
      int runs;
      int flaw;
      int n;
      runs = $urandom_range(5);
      flaw = ($urandom_range(99) < 78) ? 0 : $urandom_range(1, 5);
      for (int r = 0; r < runs; r++) begin
         n = ($urandom_range(7) == 0) ? $urandom_range(13, RUN_LIMIT) : $urandom_range(1, 12);
         add_count(n);
         add_byte(random_symbol());
      end
      case (flaw)
         1: add_byte(random_symbol());
         2: begin
            add_byte(DIGIT_LOW);
            add_byte(CHAR_WIDTH'(DIGIT_LOW + $urandom_range(9)));
         end
         3: add_count($urandom_range(RUN_LIMIT + 1, 99));
         4: add_count($urandom_range(1, RUN_LIMIT));
         5: repeat ($urandom_range(1, 6)) add_byte(CHAR_WIDTH'($urandom_range(255)));
         default: ;
      endcase
      // bytes after a failure should be dropped silently
      if (flaw != 0 && flaw != 4)
         repeat ($urandom_range(3)) add_byte(CHAR_WIDTH'($urandom_range(255)));
      add_end();
   endtask

   // ---------------------------------------------------------------- idling

   function automatic int idle_pct(input bit receiver);
      int phase;
      phase = (items_taken < phase_one_end) ? 0 : (items_taken < phase_two_end) ? 1 : 2;
      if (phase == 2)
         return 0;
      if ((phase == 0) != receiver)
         return 32;
      return 47;
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expand_item(req_symbol_byte, req_end_of_string);
            items_taken++;
            if (req_end_of_string)
               strings_done++;
         end
         if (!req_valid || req_ready) begin
            if (coded_stream.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
               next_item = coded_stream.pop_front();
               req_valid         <= 1'b1;
               req_symbol_byte   <= next_item.sym;
               req_end_of_string <= next_item.end_mark;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_outputs.size() == 0) begin
               $error("unexpected result: kind %0d char %0d total %0d last %0d",
                      rsp_result_kind, rsp_out_char, rsp_char_total, rsp_last_of_run);
               fail_count++;
            end else begin
               awaited = predicted_outputs.pop_front();
               if (rsp_result_kind !== awaited.kind) begin
                  $error("rsp_result_kind: expected %0d, got %0d", awaited.kind,
                         rsp_result_kind);
                  fail_count++;
               end
               if (rsp_out_char !== awaited.ch) begin
                  $error("rsp_out_char: expected %0d, got %0d", awaited.ch, rsp_out_char);
                  fail_count++;
               end
               if (rsp_char_total !== awaited.total) begin
                  $error("rsp_char_total: expected %0d, got %0d", awaited.total,
                         rsp_char_total);
                  fail_count++;
               end
               if (rsp_last_of_run !== awaited.last) begin
                  $error("rsp_last_of_run: expected %0d, got %0d", awaited.last,
                         rsp_last_of_run);
                  fail_count++;
               end
            end
            results_checked++;
         end
         rsp_ready <= ($urandom_range(99) >= idle_pct(1'b1));
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("no transfer for %0d cycles, %0d results still awaited", idle_cycles,
                  predicted_outputs.size());
         $display("rle_text_expander_unit regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int random_start;
      int stream_total;

      // empty string, single run, longest run of byte zero, top byte value
      add_end();
      add_count(1);
      add_byte("A");
      add_end();
      add_count(RUN_LIMIT);
      add_byte(8'h00);
      add_end();
      add_count(9);
      add_byte(8'hFF);
      add_end();
      // symbol with no count, then a dropped byte and a quiet end
      add_byte("x");
      add_byte("5");
      add_end();
      // leading zero
      add_byte(DIGIT_LOW);
      add_end();
      // count over the limit
      add_count(65);
      add_end();
      // count left pending at the end
      add_count(3);
      add_end();
      // zero as a second digit is fine
      add_count(10);
      add_byte("z");
      add_end();

      random_start = coded_stream.size();
      while (coded_stream.size() - random_start < RANDOM_ITEMS)
         add_random_string();
      stream_total  = coded_stream.size();
      phase_one_end = stream_total / 3;
      phase_two_end = 2 * stream_total / 3;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (coded_stream.size() > 0 || req_valid || predicted_outputs.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("decoded %0d strings from %0d coded items, %0d results compared",
               strings_done, items_taken, results_checked);
      $display("covered malformed strings, dropped bytes and runs up to the longest count");
      if (fail_count == 0 && predicted_outputs.size() == 0)
         $display("rle_text_expander_unit regression: pass");
      else
         $display("rle_text_expander_unit regression: fail");
      $finish;
   end

endmodule

/* filelist.f */
rtl/rlex_pkg.sv
rtl/rlex_front.sv
rtl/rlex_cmd_queue.sv
rtl/rlex_back.sv
rtl/rle_text_expander_unit.sv
bench/rle_text_expander_unit_tb.sv
